/* design/svt_pkg.sv */
// Package for the sorted value table: command and status codes, sequencer states.
// Used by sorted_value_table. Depends on nothing.
package svt_pkg;

    // Command codes, carried in tuser
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_POP    = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int OUT_W    = 48;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

endpackage

/* design/svt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module svt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/sorted_value_table.sv */
// Sorted value table top level: sequencer walking a RAM of values kept in
// descending order. Depends on svt_pkg and svt_ram.
//
// Usage:
//   Slave channel s_axis carries one command per transaction: tuser holds the
//   operation (insert, remove, pop largest), tdata the signed 32-bit value.
//   Master channel m_axis returns exactly one result per command: status,
//   popped value, entry count after the command and an empty flag.
//   Each command walks the stored list from the head, one RAM entry per
//   cycle, reading entry j+1 while writing the shifted entry j (or j-1).
//   A command passes an accept state, walk steps for j = 0 to count and a
//   finish state; a duplicate, a full table or an unused mode ends the walk
//   early. The pace of the walk is set by the single RAM read port. One
//   command is in flight at a time; the next is taken as soon as the
//   previous result sits in the output register.
//   Reset empties the table at once (no clearing pass; unused entries are
//   never read as data). If m_axis_tready is low, the result is held in the
//   output register; a next command that reaches its finish state waits there.
module sorted_value_table #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [2:0] status, [34:3] popped_value,
                                        // [39:35] entry_count,
                                        // [40] is_empty_flag, [47:41] zero
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VW    = svt_pkg::VALUE_W;

    // Control and payload registers
    svt_pkg::t_state          r_state, n_state;
    logic [1:0]               r_mode, n_mode;
    logic signed [VW-1:0]     r_value, n_value;
    logic [CNT_W-1:0]         r_j, n_j;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_hit, n_hit;
    logic [VW-1:0]            r_carry, n_carry;
    logic [VW-1:0]            r_popped, n_popped;
    logic [2:0]               r_status, n_status;
    logic                     r_out_valid, n_out_valid;
    logic [47:0]              r_out_data, n_out_data;

    // RAM interface
    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    logic [VW-1:0]            w_wr_data;
    logic [AW-1:0]            w_rd_addr;
    logic [VW-1:0]            w_rd_data;

    logic [CNT_W-1:0]         w_j_inc;
    logic [CNT_W-1:0]         w_j_dec;
    logic                     w_at_end;
    logic                     w_full;
    logic                     w_accept;
    logic [31:0]              w_cnt_ext;

    svt_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (1'b1),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign s_axis_tready = (r_state == svt_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_j_inc  = r_j + CNT_W'(1);
    assign w_j_dec  = r_j - CNT_W'(1);
    assign w_at_end = (r_j == r_count);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_cnt_ext = 32'(r_count);

    // Read ahead: entry 0 on accept, entry j+1 while entry j is processed
    assign w_rd_addr = (r_state == svt_pkg::S_WALK) ? w_j_inc[AW-1:0] : '0;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_value     = r_value;
        n_j         = r_j;
        n_count     = r_count;
        n_hit       = r_hit;
        n_carry     = r_carry;
        n_popped    = r_popped;
        n_status    = r_status;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_j[AW-1:0];
        w_wr_data   = r_carry;

        case (r_state)
            svt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_mode   = s_axis_tuser;
                    n_value  = s_axis_tdata;
                    n_j      = '0;
                    n_hit    = 1'b0;
                    n_popped = '0;
                    n_state  = svt_pkg::S_WALK;
                end
            end

            svt_pkg::S_WALK: begin
                n_j = w_j_inc;
                case (r_mode)
                    svt_pkg::MODE_INSERT: begin
                        if (w_at_end) begin
                            // Tail: append value or last shifted entry
                            n_state = svt_pkg::S_FIN;
                            if (!r_hit && w_full) begin
                                n_status = svt_pkg::ST_FULL;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_data = r_hit ? r_carry : r_value;
                                n_count   = r_count + CNT_W'(1);
                                n_status  = svt_pkg::ST_DONE;
                            end
                        end else if (r_hit) begin
                            // Shift tail down by one
                            w_wr_en   = 1'b1;
                            w_wr_data = r_carry;
                            n_carry   = w_rd_data;
                        end else if ($signed(w_rd_data) > r_value) begin
                            n_hit = 1'b0;
                        end else if (w_rd_data == r_value) begin
                            n_status = svt_pkg::ST_DUP;
                            n_state  = svt_pkg::S_FIN;
                        end else if (w_full) begin
                            n_status = svt_pkg::ST_FULL;
                            n_state  = svt_pkg::S_FIN;
                        end else begin
                            // Place value here, carry the displaced entry
                            w_wr_en   = 1'b1;
                            w_wr_data = r_value;
                            n_carry   = w_rd_data;
                            n_hit     = 1'b1;
                        end
                    end

                    svt_pkg::MODE_REMOVE, svt_pkg::MODE_POP: begin
                        if (w_at_end) begin
                            n_state = svt_pkg::S_FIN;
                            if (r_hit) begin
                                n_count  = r_count - CNT_W'(1);
                                n_status = svt_pkg::ST_DONE;
                            end else if (r_mode == svt_pkg::MODE_POP) begin
                                n_status = svt_pkg::ST_EMPTY;
                            end else begin
                                n_status = svt_pkg::ST_NOTFOUND;
                            end
                        end else if (r_hit) begin
                            // Close the gap: entry j moves to j-1
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_j_dec[AW-1:0];
                            w_wr_data = w_rd_data;
                        end else if ((r_mode == svt_pkg::MODE_POP) ||
                                     (w_rd_data == r_value)) begin
                            n_hit = 1'b1;
                            if (r_mode == svt_pkg::MODE_POP) begin
                                n_popped = w_rd_data;
                            end
                        end
                    end

                    default: begin
                        // No operation
                        n_status = svt_pkg::ST_DONE;
                        n_state  = svt_pkg::S_FIN;
                    end
                endcase
            end

            svt_pkg::S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, (r_count == '0), w_cnt_ext[4:0],
                                   r_popped, r_status};
                    n_state     = svt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = svt_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and walk registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_value    <= n_value;
        r_j        <= n_j;
        r_hit      <= n_hit;
        r_carry    <= n_carry;
        r_popped   <= n_popped;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

endmodule

/* sim/svt_result_checker.sv */
// Result checker for the sorted value table: tracks the stored values on every
// accepted command, queues the expected result and compares each returned one.
// Depends on svt_pkg.
module svt_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel, observed
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [31:0] i_cmd_data,     // [31:0] value
    input  logic [1:0]  i_cmd_mode,     // [1:0] mode
    // Result channel, observed
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [47:0] i_res_data,     // [2:0] status, [34:3] popped_value,
                                        // [39:35] entry_count, [40] is_empty_flag
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] popped;
        logic [4:0]  count;
        logic        empty;
    } t_table_result;

    // Shadow copy of the table, descending, entries [0, table_count) valid
    logic signed [31:0] table_vals [DEPTH];
    int                 table_count;
    t_table_result      expected_results [$];
    int                 fail_count;

    initial begin
        table_count  = 0;
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Apply one command to the shadow table and return the result it gives
    function automatic t_table_result apply_table_command(logic [1:0] mode,
                                                          logic signed [31:0] value);
        t_table_result res;
        int            pos;
        int            i;
        res.status = svt_pkg::ST_DONE;
        res.popped = '0;
        pos = 0;
        case (mode)
            svt_pkg::MODE_INSERT: begin
                while (pos < table_count && table_vals[pos] > value)
                    pos++;
                if (pos < table_count && table_vals[pos] == value) begin
                    res.status = svt_pkg::ST_DUP;
                end else if (table_count >= DEPTH) begin
                    res.status = svt_pkg::ST_FULL;
                end else begin
                    for (i = table_count; i > pos; i--)
                        table_vals[i] = table_vals[i-1];
                    table_vals[pos] = value;
                    table_count++;
                end
            end
            svt_pkg::MODE_REMOVE: begin
                while (pos < table_count && table_vals[pos] != value)
                    pos++;
                if (pos < table_count) begin
                    for (i = pos; i + 1 < table_count; i++)
                        table_vals[i] = table_vals[i+1];
                    table_count--;
                end else begin
                    res.status = svt_pkg::ST_NOTFOUND;
                end
            end
            svt_pkg::MODE_POP: begin
                if (table_count == 0) begin
                    res.status = svt_pkg::ST_EMPTY;
                end else begin
                    res.popped = table_vals[0];
                    for (i = 0; i + 1 < table_count; i++)
                        table_vals[i] = table_vals[i+1];
                    table_count--;
                end
            end
            default: ;  // unused mode: no change
        endcase
        res.count = table_count[4:0];
        res.empty = (table_count == 0);
        return res;
    endfunction

    // Predict on command transactions, compare on result transactions
    always @(posedge i_clk) begin : watch
        t_table_result seen_res;
        t_table_result want_res;
        if (!i_rst_n) begin
            table_count = 0;
            expected_results.delete();
        end else begin
            if (i_cmd_valid && i_cmd_ready)
                expected_results.push_back(apply_table_command(i_cmd_mode, i_cmd_data));
            if (i_res_valid && i_res_ready) begin
                seen_res.status = i_res_data[2:0];
                seen_res.popped = i_res_data[34:3];
                seen_res.count  = i_res_data[39:35];
                seen_res.empty  = i_res_data[40];
                if (expected_results.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    fail_count++;
                end else begin
                    want_res = expected_results.pop_front();
                    if (seen_res.status !== want_res.status) begin
                        $error("status: expected %0d, got %0d",
                               want_res.status, seen_res.status);
                        fail_count++;
                    end
                    if (seen_res.popped !== want_res.popped) begin
                        $error("popped_value: expected %h, got %h",
                               want_res.popped, seen_res.popped);
                        fail_count++;
                    end
                    if (seen_res.count !== want_res.count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want_res.count, seen_res.count);
                        fail_count++;
                    end
                    if (seen_res.empty !== want_res.empty) begin
                        $error("is_empty_flag: expected %0d, got %0d",
                               want_res.empty, seen_res.empty);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

/* sim/tb.sv */
// Testbench top for sorted_value_table: clock, reset, command stimulus and
// result back-pressure; checking is done in svt_result_checker.
// Depends on svt_pkg, sorted_value_table and svt_result_checker.
module tb;

    localparam int         DEPTH       = 16;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 400;
    localparam logic [1:0] MODE_NOP    = 2'd3;
    localparam int         POOL_SIZE   = 24;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;    // [31:0] value
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [2:0] status, [34:3] popped_value,
                                        // [39:35] entry_count, [40] is_empty_flag

    int          fail_count;
    int          pending_count;
    int          cycle_count   = 0;
    int          rx_idle_pct   = 69;
    int          tx_idle_pct   = 24;
    logic        hold_req      = 1'b0;
    logic        hold_done     = 1'b0;
    int          hold_left     = 0;
    logic [31:0] value_pool [POOL_SIZE];

    // Distinct values that fill the table, extremes included
    logic [31:0] fill_values [DEPTH] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h4000_0000,
        32'hC000_0000, 32'h00FF_00FF, 32'hFF00_FF00, 32'h0000_3039,
        32'hFFFF_CFC7, 32'h7FFF_FFFE, 32'h8000_0001, 32'h0F0F_0F0F
    };

    sorted_value_table #(.DEPTH(DEPTH)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    svt_result_checker #(.DEPTH(DEPTH)) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (s_axis_tvalid),
        .i_cmd_ready  (s_axis_tready),
        .i_cmd_data   (s_axis_tdata),
        .i_cmd_mode   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // One command transaction, with random idle cycles ahead of it
    task automatic send_command(input logic [1:0] mode, input logic [31:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Mostly pool values so removes and duplicates hit, some extremes, rest random
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        if (r < 66)
            return fill_values[$urandom_range(3)];
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_mode(int insert_pct);
        int r;
        r = $urandom_range(99);
        if (r < insert_pct)
            return svt_pkg::MODE_INSERT;
        r = $urandom_range(99);
        if (r < 55)
            return svt_pkg::MODE_REMOVE;
        if (r < 95)
            return svt_pkg::MODE_POP;
        return MODE_NOP;
    endfunction

    initial begin
        int insert_pct;
        int n;
        int k;
        for (k = 0; k < POOL_SIZE; k++)
            value_pool[k] = $urandom;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table cases, one-entry miss, fill, full and duplicate
        send_command(svt_pkg::MODE_POP, 32'h0);
        send_command(svt_pkg::MODE_REMOVE, 32'h5);
        send_command(MODE_NOP, 32'hFFFF_FFFF);
        send_command(svt_pkg::MODE_INSERT, 32'h0);
        send_command(svt_pkg::MODE_REMOVE, 32'h5);
        send_command(svt_pkg::MODE_REMOVE, 32'h0);
        for (k = 0; k < DEPTH; k++)
            send_command(svt_pkg::MODE_INSERT, fill_values[k]);
        send_command(svt_pkg::MODE_INSERT, 32'h0000_0063);
        send_command(svt_pkg::MODE_INSERT, 32'h0);
        send_command(svt_pkg::MODE_POP, 32'h0);

        // Random: three idle settings, long result hold-off in the last one
        insert_pct = 50;
        for (n = 0; n < 1200; n++) begin
            if (n == 400) begin
                tx_idle_pct = 69;
                rx_idle_pct <= 24;
            end
            if (n == 800) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                hold_req    <= 1'b1;
            end
            if (n % 64 == 0) begin
                case ($urandom_range(2))
                    0:       insert_pct = 20;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            send_command(pick_mode(insert_pct), pick_value());
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        // Drain, then allow for a late or spurious result
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DEPTH + 24) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
